// File: design/xee_pkg.sv
`default_nettype none
package xee_pkg;

	localparam int MAX_OUT = 5;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);

	localparam logic DIR_ESCAPE   = 1'b0;
	localparam logic DIR_UNESCAPE = 1'b1;

	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] data;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} job_t;

endpackage
`default_nettype wire

// File: design/xee_in_if.sv
`default_nettype none
interface xee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface
`default_nettype wire

// File: design/xee_out_if.sv
`default_nettype none
interface xee_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

// File: design/xee_front.sv
`default_nettype none
module xee_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	xee_in_if.sink        in_ch,
	output logic          job_valid,
	output xee_pkg::job_t job,
	input  wire logic     job_ready
);

	localparam logic [3:0] P_IDLE = 4'd0;
	localparam logic [3:0] P_AMP  = 4'd1;
	localparam logic [3:0] P_L    = 4'd2;
	localparam logic [3:0] P_LT   = 4'd3;
	localparam logic [3:0] P_G    = 4'd4;
	localparam logic [3:0] P_GT   = 4'd5;
	localparam logic [3:0] P_A    = 4'd6;
	localparam logic [3:0] P_AM   = 4'd7;
	localparam logic [3:0] P_AMPP = 4'd8;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_G    = 8'h67;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_P    = 8'h70;

	function automatic logic [xee_pkg::CNT_W-1:0] prefix_len(input logic [3:0] s);
		case (s)
			P_AMP:                 prefix_len = xee_pkg::CNT_W'(1);
			P_L, P_G, P_A:         prefix_len = xee_pkg::CNT_W'(2);
			P_LT, P_GT, P_AM:      prefix_len = xee_pkg::CNT_W'(3);
			P_AMPP:                prefix_len = xee_pkg::CNT_W'(4);
			default:               prefix_len = '0;
		endcase
	endfunction

	function automatic logic [7:0] prefix_char(input logic [3:0] s,
			input logic [xee_pkg::CNT_W-1:0] k);
		logic [7:0] ch;
		ch = CH_AMP;
		case (k)
			xee_pkg::CNT_W'(1): begin
				if (s == P_L || s == P_LT) ch = CH_L;
				else if (s == P_G || s == P_GT) ch = CH_G;
				else ch = CH_A;
			end
			xee_pkg::CNT_W'(2): begin
				if (s == P_LT || s == P_GT) ch = CH_T;
				else ch = CH_M;
			end
			xee_pkg::CNT_W'(3): ch = CH_P;
			default: ch = CH_AMP;
		endcase
		return ch;
	endfunction

	logic                       dir_q;
	logic [3:0]                 prog_q;
	logic [3:0]                 prog_next;
	logic [3:0]                 hit_next;
	logic                       hit;
	logic                       term;
	logic [7:0]                 term_char;
	logic [7:0]                 c;
	logic                       last;
	logic [xee_pkg::CNT_W-1:0]  plen;
	logic                       accept;

	assign c      = in_ch.in_byte;
	assign last   = in_ch.end_of_string;
	assign plen   = prefix_len(prog_q);
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		hit       = 1'b0;
		term      = 1'b0;
		term_char = CH_AMP;
		hit_next  = P_IDLE;
		case (prog_q)
			P_AMP: begin
				if (c == CH_L) begin
					hit = 1'b1; hit_next = P_L;
				end else if (c == CH_G) begin
					hit = 1'b1; hit_next = P_G;
				end else if (c == CH_A) begin
					hit = 1'b1; hit_next = P_A;
				end
			end
			P_L: begin
				if (c == CH_T) begin
					hit = 1'b1; hit_next = P_LT;
				end
			end
			P_G: begin
				if (c == CH_T) begin
					hit = 1'b1; hit_next = P_GT;
				end
			end
			P_A: begin
				if (c == CH_M) begin
					hit = 1'b1; hit_next = P_AM;
				end
			end
			P_AM: begin
				if (c == CH_P) begin
					hit = 1'b1; hit_next = P_AMPP;
				end
			end
			P_LT: begin
				if (c == CH_SEMI) begin
					hit = 1'b1; term = 1'b1; term_char = CH_LT;
				end
			end
			P_GT: begin
				if (c == CH_SEMI) begin
					hit = 1'b1; term = 1'b1; term_char = CH_GT;
				end
			end
			P_AMPP: begin
				if (c == CH_SEMI) begin
					hit = 1'b1; term = 1'b1; term_char = CH_AMP;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		job.last  = last;
		job.data  = '0;
		job.count = '0;
		prog_next = P_IDLE;
		if (dir_q == xee_pkg::DIR_ESCAPE) begin
			if (c == CH_LT) begin
				job.data[0] = CH_AMP; job.data[1] = CH_L; job.data[2] = CH_T;
				job.data[3] = CH_SEMI;
				job.count = xee_pkg::CNT_W'(4);
			end else if (c == CH_GT) begin
				job.data[0] = CH_AMP; job.data[1] = CH_G; job.data[2] = CH_T;
				job.data[3] = CH_SEMI;
				job.count = xee_pkg::CNT_W'(4);
			end else if (c == CH_AMP) begin
				job.data[0] = CH_AMP; job.data[1] = CH_A; job.data[2] = CH_M;
				job.data[3] = CH_P; job.data[4] = CH_SEMI;
				job.count = xee_pkg::CNT_W'(5);
			end else begin
				job.data[0] = c;
				job.count = xee_pkg::CNT_W'(1);
			end
		end else begin
			for (int k = 0; k < xee_pkg::MAX_OUT; k++) begin
				job.data[k] = (xee_pkg::CNT_W'(k) < plen)
					? prefix_char(prog_q, xee_pkg::CNT_W'(k)) : c;
			end
			if (hit && term) begin
				job.data[0] = term_char;
				job.count = xee_pkg::CNT_W'(1);
			end else if (hit && !last) begin
				job.count = '0;
				prog_next = hit_next;
			end else if (!hit && c == CH_AMP && !last) begin
				job.count = plen;
				prog_next = P_AMP;
			end else begin
				job.count = plen + xee_pkg::CNT_W'(1);
			end
		end
	end

	assign in_ch.ready = job_ready;
	assign job_valid   = in_ch.valid && (job.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= xee_pkg::DIR_ESCAPE;
			prog_q <= P_IDLE;
		end else if (cfg_we) begin
			dir_q  <= cfg_wdata;
			prog_q <= P_IDLE;
		end else if (accept) begin
			prog_q <= prog_next;
		end
	end

endmodule
`default_nettype wire

// File: design/xee_queue.sv
`default_nettype none
module xee_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire xee_pkg::job_t  push_job,
	output logic                push_ready,
	input  wire logic           pop,
	output logic                head_valid,
	output xee_pkg::job_t       head
);

	xee_pkg::job_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// File: design/xee_back.sv
`default_nettype none
module xee_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire xee_pkg::job_t head,
	output logic               pop,
	xee_out_if.source          out_ch
);

	logic [xee_pkg::CNT_W-1:0] pos_q;
	logic                      at_end;
	logic                      fire;

	assign at_end          = (pos_q == head.count - xee_pkg::CNT_W'(1));
	assign fire            = out_ch.valid && out_ch.ready;
	assign pop             = fire && at_end;
	assign out_ch.valid    = head_valid;
	assign out_ch.out_byte = head.data[pos_q];
	assign out_ch.out_last = head.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (fire) begin
			// advance within the request, wrap when it is done
			pos_q <= at_end ? '0 : pos_q + xee_pkg::CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: design/xee_top_note.sv
`default_nettype none
module xee_job_check (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire xee_pkg::job_t job,
	output logic               job_ok
);

	logic ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ok_q <= 1'b1;
		else if (job_valid && (job.count == '0 || job.count > xee_pkg::CNT_W'(xee_pkg::MAX_OUT)))
			ok_q <= 1'b0;
	end

	assign job_ok = ok_q;

endmodule
`default_nettype wire

// File: design/xml_entity_escape_unescape.sv
// XML entity converter: in escape mode '<', '>' and '&' become "&lt;", "&gt;" and "&amp;";
// in unescape mode those three entities collapse to one character, a broken prefix is passed
// on as text and a prefix held at end_of_string is flushed. Set direction through cfg_we and
// cfg_wdata only while no string is in flight; a write drops any held prefix. One input byte
// is taken per cycle while the two-entry request queue has room, and the output serializer
// sends one byte per cycle while out_ch.ready is high, so a byte that expands to up to five
// output bytes holds the output until all are sent; a stream of bytes with one result each
// runs at one byte per cycle with a ready sink. Requests are registered in the queue first.
`default_nettype none
module xml_entity_escape_unescape (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	xee_in_if.sink    in_ch,
	xee_out_if.source out_ch
);

	logic          job_valid;
	xee_pkg::job_t job;
	logic          job_ready;
	logic          q_pop;
	logic          q_valid;
	xee_pkg::job_t q_head;
	logic          job_ok;

	xee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready)
	);

	xee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.push_ready (job_ready),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	xee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_ch     (out_ch)
	);

	xee_job_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ok    (job_ok)
	);

	a_job_count: assert property (@(posedge clk) disable iff (!arst_n) job_ok)
		else $error("request with bad byte count");

	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.out_last) |-> q_pop)
		else $error("last byte sent without retiring its request");

	a_pop_fires: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (out_ch.valid && out_ch.ready && q_valid))
		else $error("request retired without a transfer");

endmodule
`default_nettype wire

// File: tb/sv/xml_entity_escape_unescape_tb.sv
`timescale 1ns / 1ps
module xml_entity_escape_unescape_tb;

	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_GUARD = 20000;

	typedef enum logic [3:0] {
		M_NONE = 4'd0,
		M_AMP  = 4'd1,
		M_L    = 4'd2,
		M_LT   = 4'd3,
		M_G    = 4'd4,
		M_GT   = 4'd5,
		M_A    = 4'd6,
		M_AM   = 4'd7,
		M_AMP4 = 4'd8
	} match_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} conv_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	xee_in_if in_ch();
	xee_out_if out_ch();

	xml_entity_escape_unescape u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	logic       dir_model = xee_pkg::DIR_ESCAPE;
	match_t     entity_match = M_NONE;
	logic [7:0] step_chars[$];
	conv_char_t expected_chars[$];

	int  src_idle_pct = 0;
	int  sink_stall_pct = 0;
	logic hold_go = 1'b0;
	int  mismatches = 0;
	int  requests_sent = 0;
	int  bytes_checked = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [8:0] got,
			input logic [8:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic string match_text(input match_t m);
		case (m)
			M_AMP:   return "&";
			M_L:     return "&l";
			M_LT:    return "&lt";
			M_G:     return "&g";
			M_GT:    return "&gt";
			M_A:     return "&a";
			M_AM:    return "&am";
			M_AMP4:  return "&amp";
			default: return "";
		endcase
	endfunction

	function automatic void push_char(input logic [7:0] c);
		if (step_chars.size() < xee_pkg::MAX_OUT)
			step_chars.insert(step_chars.size(), c);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endfunction

	function automatic void predict_conversion(input logic [7:0] c, input logic eos);
		match_t     nxt;
		logic       hit;
		conv_char_t item;
		nxt = M_NONE;
		hit = 1'b0;
		step_chars.delete();
		if (dir_model == xee_pkg::DIR_ESCAPE) begin
			entity_match = M_NONE;
			if (c == "<")
				push_text("&lt;");
			else if (c == ">")
				push_text("&gt;");
			else if (c == "&")
				push_text("&amp;");
			else
				push_char(c);
		end else begin
			case (entity_match)
				M_AMP: begin
					if (c == "l") begin
						nxt = M_L;
						hit = 1'b1;
					end else if (c == "g") begin
						nxt = M_G;
						hit = 1'b1;
					end else if (c == "a") begin
						nxt = M_A;
						hit = 1'b1;
					end
				end
				M_L: if (c == "t") begin
					nxt = M_LT;
					hit = 1'b1;
				end
				M_G: if (c == "t") begin
					nxt = M_GT;
					hit = 1'b1;
				end
				M_A: if (c == "m") begin
					nxt = M_AM;
					hit = 1'b1;
				end
				M_AM: if (c == "p") begin
					nxt = M_AMP4;
					hit = 1'b1;
				end
				M_LT: if (c == ";") begin
					push_char("<");
					hit = 1'b1;
				end
				M_GT: if (c == ";") begin
					push_char(">");
					hit = 1'b1;
				end
				M_AMP4: if (c == ";") begin
					push_char("&");
					hit = 1'b1;
				end
				default: ;
			endcase
			if (hit) begin
				entity_match = nxt;
			end else begin
				push_text(match_text(entity_match));
				if (c == "&") begin
					entity_match = M_AMP;
				end else begin
					entity_match = M_NONE;
					push_char(c);
				end
			end
			if (eos) begin
				push_text(match_text(entity_match));
				entity_match = M_NONE;
			end
		end
		for (int i = 0; i < step_chars.size(); i++) begin
			item.data = step_chars[i];
			item.last = eos && (i == step_chars.size() - 1);
			expected_chars.insert(expected_chars.size(), item);
		end
	endfunction

	always @(posedge clk) begin : check_output
		conv_char_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			bytes_checked++;
			if (expected_chars.size() == 0) begin
				report_mismatch("unexpected byte", {out_ch.out_byte, out_ch.out_last}, 9'h0);
			end else begin
				want = expected_chars.pop_front();
				if (out_ch.out_byte !== want.data)
					report_mismatch("out_byte", {1'b0, out_ch.out_byte}, {1'b0, want.data});
				if (out_ch.out_last !== want.last)
					report_mismatch("out_last", {8'h0, out_ch.out_last}, {8'h0, want.last});
			end
		end
		out_ch.ready <= !hold_go && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always begin
		wait (hold_go);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_go <= 1'b0;
		@(posedge clk);
	end

	task automatic send_request(input logic [7:0] b, input logic eos);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.end_of_string <= eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		requests_sent++;
		predict_conversion(b, eos);
	endtask

	task automatic send_text(input string s, input logic eos_at_end);
		for (int i = 0; i < s.len(); i++)
			send_request(s[i], eos_at_end && (i == s.len() - 1));
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (expected_chars.size() > 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		if (expected_chars.size() > 0) begin
			report_mismatch("bytes never delivered", 9'(expected_chars.size()), 9'h0);
			expected_chars.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		dir_model = d;
		entity_match = M_NONE;
	endtask

	task automatic send_random_string(input int max_len);
		logic [7:0] str[$];
		string      ent;
		string      specials;
		int         target;
		int         cut;
		bit         noise;
		specials = "<>&;lgtamp";
		target = $urandom_range(1, max_len);
		noise = ($urandom_range(0, 99) < 20);
		while (str.size() < target) begin
			case ($urandom_range(0, 2))
				0: ent = "&lt;";
				1: ent = "&gt;";
				default: ent = "&amp;";
			endcase
			if (noise) begin
				str.insert(str.size(), 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 3))
					0: str.insert(str.size(), 8'($urandom_range(0, 255)));
					1: for (int i = 0; i < ent.len(); i++)
						str.insert(str.size(), ent[i]);
					2: begin
						cut = $urandom_range(1, ent.len() - 1);
						for (int i = 0; i < cut; i++)
							str.insert(str.size(), ent[i]);
					end
					default: str.insert(str.size(),
						specials[$urandom_range(0, specials.len() - 1)]);
				endcase
			end
		end
		for (int i = 0; i < str.size(); i++)
			send_request(str[i], i == str.size() - 1);
	endtask

	task automatic test_directed_escape();
		write_direction(xee_pkg::DIR_ESCAPE);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		send_request(8'h00, 1'b0);
		send_request(8'hff, 1'b0);
		send_request("<", 1'b0);
		send_request(">", 1'b0);
		send_request("&", 1'b1);
	endtask

	task automatic test_directed_unescape();
		write_direction(xee_pkg::DIR_UNESCAPE);
		write_direction(xee_pkg::DIR_UNESCAPE);
		// nested ampersand, then all three entities
		send_text("&&lt;&gt;&amp;", 1'b0);
		// entity cut by the end of the string
		send_text("&amp", 1'b1);
		// held prefix dropped by a direction write
		send_text("&g", 1'b0);
		write_direction(xee_pkg::DIR_UNESCAPE);
		send_text("x", 1'b1);
	endtask

	task automatic test_random_phase(input logic d, input int src_pct, input int snk_pct,
			input int n);
		int start;
		write_direction(d);
		src_idle_pct = src_pct;
		sink_stall_pct = snk_pct;
		start = requests_sent;
		while (requests_sent - start < n)
			send_random_string(12);
	endtask

	task automatic test_random_traffic();
		test_random_phase(xee_pkg::DIR_ESCAPE, 0, 0, 32);
		test_random_phase(xee_pkg::DIR_UNESCAPE, 0, 0, 32);
		test_random_phase(xee_pkg::DIR_ESCAPE, 63, 0, 32);
		test_random_phase(xee_pkg::DIR_UNESCAPE, 63, 0, 32);
		test_random_phase(xee_pkg::DIR_UNESCAPE, 0, 63, 32);
		test_random_phase(xee_pkg::DIR_ESCAPE, 0, 63, 32);
		test_random_phase(xee_pkg::DIR_UNESCAPE, 14, 14, 32);
		test_random_phase(xee_pkg::DIR_ESCAPE, 14, 14, 32);
	endtask

	task automatic test_output_holdoff();
		write_direction(xee_pkg::DIR_ESCAPE);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		// hold the output while requests keep coming
		hold_go <= 1'b1;
		for (int i = 0; i < 30; i++) begin
			case ($urandom_range(0, 3))
				0: send_request("<", i == 29);
				1: send_request(">", i == 29);
				2: send_request("&", i == 29);
				default: send_request(8'($urandom_range(0, 255)), i == 29);
			endcase
		end
	endtask

	task automatic test_drain_pause();
		write_direction(xee_pkg::DIR_UNESCAPE);
		src_idle_pct = 14;
		sink_stall_pct = 14;
		repeat (3) send_random_string(10);
		wait_drained();
		send_text("&lt", 1'b0);
		wait_drained();
		send_text(";&am", 1'b1);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.end_of_string = 1'b0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_escape();
		test_directed_unescape();
		test_random_traffic();
		test_output_holdoff();
		test_drain_pause();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d requests and %0d output bytes in both directions",
			requests_sent, bytes_checked);
		$display("with idle and stall mixes, a long output hold-off and drain pauses");
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule
